@@ sv/numa_address_node_map_defines.svh @@
// assertion macros shared by the numa address node map modules
`ifndef NUMA_ADDRESS_NODE_MAP_DEFINES_SVH
`define NUMA_ADDRESS_NODE_MAP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define NUMA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("numa map property violated");
// condition must never be seen outside reset
`define NUMA_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("numa map forbidden condition seen");
`else
`define NUMA_ASSERT(lbl, prop)
`define NUMA_NEVER(lbl, expr)
`endif

`endif

@@ sv/numa_map_pkg.sv @@
package numa_map_pkg;

   localparam int SLOTS  = 64;
   localparam int RANGES = 32;
   localparam int NODES  = 16;

   localparam int SLOT_IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RANGE_IDX_W  = (RANGES > 1) ? $clog2(RANGES) : 1;
   localparam int FILL_W       = $clog2(RANGES + 1);
   localparam int NODE_W       = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int NODE_TOTAL_W = 5;

   // power of two so the pointers wrap on their own
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] REQ_CPU_ENTRY   = 2'd0;
   localparam logic [1:0] REQ_MEM_ENTRY   = 2'd1;
   localparam logic [1:0] REQ_ADDR_LOOKUP = 2'd2;
   localparam logic [1:0] REQ_SLOT_LOOKUP = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        entry_enabled;
      logic [31:0] entry_domain;
      logic [7:0]  cpu_slot;
      logic [31:0] range_start;
      logic [31:0] range_size;
      logic [31:0] lookup_address;
   } req_item_type;

   typedef struct packed {
      logic [31:0]             node;
      logic                    found;
      logic [NODE_TOTAL_W-1:0] node_total;
   } rsp_item_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_SLOT_WRITE,
      CMD_RANGE_ADD,
      CMD_ADDR_LOOKUP,
      CMD_SLOT_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [31:0]           domain;
      logic [SLOT_IDX_W-1:0] slot;
      logic [31:0]           address;
      logic [31:0]           length;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ sv/numa_map_front.sv @@
module numa_map_front
   import numa_map_pkg::*;
(
   input  logic             start,
   input  req_item_type     req_item,
   input  queue_status_type q_status,
   output logic             busy,
   output logic             push,
   output cmd_type          push_cmd
);

   logic slot_ok;
   logic domain_ok;

   assign slot_ok   = {1'b0, req_item.cpu_slot} < 9'(SLOTS);
   assign domain_ok = req_item.entry_domain < 32'(NODES);

   assign busy = q_status.full;
   assign push = start && !q_status.full;

   // disabled or out of range entries and out of range slot reads become no-ops
   always_comb begin
      push_cmd.kind    = CMD_NOP;
      push_cmd.domain  = req_item.entry_domain;
      push_cmd.slot    = req_item.cpu_slot[SLOT_IDX_W-1:0];
      push_cmd.address = req_item.range_start;
      push_cmd.length  = req_item.range_size;
      unique case (req_item.req_type)
         REQ_CPU_ENTRY: begin
            if (req_item.entry_enabled && slot_ok) push_cmd.kind = CMD_SLOT_WRITE;
         end
         REQ_MEM_ENTRY: begin
            if (req_item.entry_enabled && domain_ok) push_cmd.kind = CMD_RANGE_ADD;
         end
         REQ_ADDR_LOOKUP: begin
            push_cmd.kind    = CMD_ADDR_LOOKUP;
            push_cmd.address = req_item.lookup_address;
         end
         REQ_SLOT_LOOKUP: begin
            if (slot_ok) push_cmd.kind = CMD_SLOT_READ;
         end
      endcase
   end

endmodule

@@ sv/numa_map_queue.sv @@
`include "numa_address_node_map_defines.svh"

module numa_map_queue
   import numa_map_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type q_status
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         if (push && !pop) count_ff <= count_ff + QUEUE_CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;

   `NUMA_NEVER(a_queue_no_overflow, push && q_status.full)
   `NUMA_NEVER(a_queue_no_underflow, pop && q_status.empty)

endmodule

@@ sv/numa_map_back.sv @@
`include "numa_address_node_map_defines.svh"

module numa_map_back
   import numa_map_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          head_cmd,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_strobe,
   output rsp_item_type     rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SLOT_WAIT,
      ST_SCAN
   } state_type;

   state_type               state_ff;
   cmd_type                 cmd_ff;
   logic [NODE_TOTAL_W-1:0] count_ff;
   logic [FILL_W-1:0]       fill_ff;
   logic [FILL_W-1:0]       scan_idx_ff;
   logic                    rd_pend_ff;
   logic                    rsp_strobe_ff;
   rsp_item_type            rsp_ff;

   logic [31:0]       slot_mem [SLOTS];
   logic [SLOTS-1:0]  slot_valid_ff;
   logic [31:0]       slot_rd_ff;
   logic              slot_rd_valid_ff;

   logic [31:0]       range_base_mem [RANGES];
   logic [31:0]       range_len_mem [RANGES];
   logic [NODE_W-1:0] range_node_mem [RANGES];
   logic [31:0]       base_rd_ff;
   logic [31:0]       len_rd_ff;
   logic [NODE_W-1:0] node_rd_ff;

   logic                    raise;
   logic                    count_up;
   logic [NODE_TOTAL_W-1:0] count_raised;
   logic                    slot_we;
   logic                    range_we;
   logic                    scan_issue;
   logic [32:0]             addr_ext;
   logic [32:0]             lo_ext;
   logic [32:0]             hi_ext;
   logic                    hit;

   assign raise        = (cmd_ff.domain >= 32'(count_ff)) && (cmd_ff.domain < 32'(NODES));
   assign count_up     = raise && ((cmd_ff.kind == CMD_SLOT_WRITE)
                                   || (cmd_ff.kind == CMD_RANGE_ADD));
   assign count_raised = NODE_TOTAL_W'(cmd_ff.domain[NODE_W-1:0]) + NODE_TOTAL_W'(1);
   assign slot_we      = (state_ff == ST_EXEC) && (cmd_ff.kind == CMD_SLOT_WRITE);
   assign range_we     = (state_ff == ST_EXEC) && (cmd_ff.kind == CMD_RANGE_ADD)
                         && (fill_ff < FILL_W'(RANGES));
   assign scan_issue   = (state_ff == ST_SCAN) && (scan_idx_ff < fill_ff);

   // range end on 33 bits so it never wraps
   assign addr_ext = {1'b0, cmd_ff.address};
   assign lo_ext   = {1'b0, base_rd_ff};
   assign hi_ext   = lo_ext + {1'b0, len_rd_ff};
   assign hit      = rd_pend_ff && (addr_ext >= lo_ext) && (addr_ext < hi_ext);

   assign pop = (state_ff == ST_IDLE) && !q_status.empty;

   // slot map, unwritten slots read as zero through the valid bits
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[cmd_ff.slot] <= cmd_ff.domain;
      slot_rd_ff       <= slot_mem[cmd_ff.slot];
      slot_rd_valid_ff <= slot_valid_ff[cmd_ff.slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (slot_we) begin
         slot_valid_ff[cmd_ff.slot] <= 1'b1;
      end
   end

   // range table, one write port at the fill index, one read port for the walk
   always_ff @(posedge clock) begin
      if (range_we) begin
         range_base_mem[fill_ff[RANGE_IDX_W-1:0]] <= cmd_ff.address;
         range_len_mem[fill_ff[RANGE_IDX_W-1:0]]  <= cmd_ff.length;
         range_node_mem[fill_ff[RANGE_IDX_W-1:0]] <= cmd_ff.domain[NODE_W-1:0];
      end
      base_rd_ff <= range_base_mem[scan_idx_ff[RANGE_IDX_W-1:0]];
      len_rd_ff  <= range_len_mem[scan_idx_ff[RANGE_IDX_W-1:0]];
      node_rd_ff <= range_node_mem[scan_idx_ff[RANGE_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= NODE_TOTAL_W'(1);
         fill_ff       <= '0;
         scan_idx_ff   <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_strobe_ff <= 1'b0;
               if (!q_status.empty) begin
                  cmd_ff      <= head_cmd;
                  scan_idx_ff <= '0;
                  rd_pend_ff  <= 1'b0;
                  state_ff    <= (head_cmd.kind == CMD_ADDR_LOOKUP) ? ST_SCAN : ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_ff.node       <= '0;
               rsp_ff.found      <= 1'b0;
               rsp_ff.node_total <= count_up ? count_raised : count_ff;
               if (count_up) count_ff <= count_raised;
               if (range_we) fill_ff <= fill_ff + FILL_W'(1);
               if (cmd_ff.kind == CMD_SLOT_READ) begin
                  rsp_strobe_ff <= 1'b0;
                  state_ff      <= ST_SLOT_WAIT;
               end else begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_SLOT_WAIT: begin
               rsp_ff.node       <= slot_rd_valid_ff ? slot_rd_ff : '0;
               rsp_ff.found      <= 1'b0;
               rsp_ff.node_total <= count_ff;
               rsp_strobe_ff     <= 1'b1;
               state_ff          <= ST_IDLE;
            end
            ST_SCAN: begin
               rd_pend_ff    <= scan_issue;
               rsp_strobe_ff <= hit || !scan_issue;
               if (scan_issue) scan_idx_ff <= scan_idx_ff + FILL_W'(1);
               if (hit) begin
                  rsp_ff.node       <= 32'(node_rd_ff);
                  rsp_ff.found      <= 1'b1;
                  rsp_ff.node_total <= count_ff;
                  state_ff          <= ST_IDLE;
               end else if (!scan_issue) begin
                  rsp_ff.node       <= '0;
                  rsp_ff.found      <= 1'b0;
                  rsp_ff.node_total <= count_ff;
                  state_ff          <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `NUMA_ASSERT(a_rsp_follows_work, rsp_strobe_ff |-> $past(state_ff) != ST_IDLE)
   `NUMA_ASSERT(a_count_never_drops, !$past(reset) |-> count_ff >= $past(count_ff))
   `NUMA_ASSERT(a_scan_within_fill, scan_idx_ff <= fill_ff)

endmodule

@@ sv/numa_address_node_map.sv @@
// Maps proximity-domain affinity entries to nodes and answers lookups. A request
// transfer happens when start is high and busy is low; a two-entry queue sits
// between the classifier and the execution engine, so up to two more requests
// are taken while one is being carried out. Each request gives exactly one
// result, shown for one cycle with rsp_strobe high; the receiver cannot stall.
// Processor and memory entries and out of range slot lookups pass through the
// queue, the idle state and the execute state; a slot lookup adds a wait state
// because the slot map read is registered, and an address lookup walks the
// range table, which holds fill stored ranges, one entry per cycle through its
// single read port and stops at the first match. The slot map is
// cleared at reset by per-slot valid bits, so there is no clearing pass.
module numa_address_node_map
   import numa_map_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_item_type req_item,
   output logic         busy,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;

   numa_map_front u_front (
      .start    (start),
      .req_item (req_item),
      .q_status (q_status),
      .busy     (busy),
      .push     (push),
      .push_cmd (push_cmd)
   );

   numa_map_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   numa_map_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
